### rtl/frc_pkg.sv
package frc_pkg;

   // Payload of one request transaction.
   typedef struct packed {
      logic signed [15:0] incident_x;
      logic signed [15:0] incident_y;
      logic signed [15:0] incident_z;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
   } req_type;

   // Payload of one response transaction.
   typedef struct packed {
      logic [16:0] reflectance;
      logic        total_internal;
   } rsp_type;

   localparam int          QFRAC      = 30;
   localparam int          QW         = QFRAC + 1;
   localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
   localparam logic [13:0] IOR_ONE    = 14'd4096;
   localparam logic [13:0] IOR_RESET  = 14'd6144;
   localparam logic [16:0] OUT_ONE    = 17'd65536;

endpackage

### rtl/frc_div.sv
// Restoring divider, one quotient bit per register stage.
// Quotient = floor((in_rem * 2^QW + in_bits) / in_den), valid when in_rem < in_den.
module frc_div #(
   parameter int QW = 31,
   parameter int DW = 28,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [SW-1:0] in_side,
   input  logic [DW-1:0] in_rem,
   input  logic [QW-1:0] in_bits,
   input  logic [DW-1:0] in_den,
   output logic          out_valid,
   output logic [SW-1:0] out_side,
   output logic [QW-1:0] out_quot
);

   logic          v_ff    [QW];
   logic [DW-1:0] rem_ff  [QW];
   logic [DW-1:0] den_ff  [QW];
   logic [QW-1:0] bits_ff [QW];
   logic [QW-1:0] quot_ff [QW];
   logic [SW-1:0] side_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic          v_p;
      logic [DW-1:0] rem_p;
      logic [DW-1:0] den_p;
      logic [QW-1:0] bits_p;
      logic [QW-1:0] quot_p;
      logic [SW-1:0] side_p;
      logic [DW:0]   trial;
      logic          ge;

      if (k == 0) begin : g_first
         assign v_p    = in_valid;
         assign rem_p  = in_rem;
         assign den_p  = in_den;
         assign bits_p = in_bits;
         assign quot_p = '0;
         assign side_p = in_side;
      end else begin : g_next
         assign v_p    = v_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign den_p  = den_ff[k-1];
         assign bits_p = bits_ff[k-1];
         assign quot_p = quot_ff[k-1];
         assign side_p = side_ff[k-1];
      end

      assign trial = {rem_p, bits_p[QW-1]};
      assign ge    = trial >= {1'b0, den_p};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? DW'(trial - {1'b0, den_p}) : trial[DW-1:0];
            den_ff[k]  <= den_p;
            bits_ff[k] <= bits_p << 1;
            quot_ff[k] <= {quot_p[QW-2:0], ge};
            side_ff[k] <= side_p;
         end
      end
   end

   assign out_valid = v_ff[QW-1];
   assign out_side  = side_ff[QW-1];
   assign out_quot  = quot_ff[QW-1];

endmodule

### rtl/frc_sqrt.sv
// Digit-by-digit integer square root, one root bit per register stage.
// out_root = floor(sqrt(in_rad)).
module frc_sqrt #(
   parameter int QW = 31,
   parameter int SW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [SW-1:0]   in_side,
   input  logic [2*QW-1:0] in_rad,
   output logic            out_valid,
   output logic [SW-1:0]   out_side,
   output logic [QW-1:0]   out_root
);

   localparam int RW = QW + 2;

   logic            v_ff    [QW];
   logic [RW-1:0]   rem_ff  [QW];
   logic [2*QW-1:0] rad_ff  [QW];
   logic [QW-1:0]   root_ff [QW];
   logic [SW-1:0]   side_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic            v_p;
      logic [RW-1:0]   rem_p;
      logic [2*QW-1:0] rad_p;
      logic [QW-1:0]   root_p;
      logic [SW-1:0]   side_p;
      logic [RW+1:0]   t;
      logic [RW-1:0]   trial;
      logic            ge;

      if (k == 0) begin : g_first
         assign v_p    = in_valid;
         assign rem_p  = '0;
         assign rad_p  = in_rad;
         assign root_p = '0;
         assign side_p = in_side;
      end else begin : g_next
         assign v_p    = v_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign rad_p  = rad_ff[k-1];
         assign root_p = root_ff[k-1];
         assign side_p = side_ff[k-1];
      end

      assign t     = {rem_p, rad_p[2*QW-1 -: 2]};
      assign trial = {root_p, 2'b01};
      assign ge    = t >= (RW+2)'(trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? RW'(t - (RW+2)'(trial)) : t[RW-1:0];
            rad_ff[k]  <= rad_p << 2;
            root_ff[k] <= {root_p[QW-2:0], ge};
            side_ff[k] <= side_p;
         end
      end
   end

   assign out_valid = v_ff[QW-1];
   assign out_side  = side_ff[QW-1];
   assign out_root  = root_ff[QW-1];

endmodule

### rtl/fresnel_reflectance_core.sv
// Channel    Direction  Handshake                Payload
// request    in         req_valid / req_stall    req_data    (frc_pkg::req_type)
// response   out        rsp_valid / rsp_stall    rsp_data    (frc_pkg::rsp_type)
// register   in         csr_wr_en                csr_wr_data (refractive index, Q2.12)
//
// One transaction enters per cycle while req_stall is low.
// Most of the pipeline depth lies in the three bit-serial pipelines: the Snell divider, the cosine
// square root and the pair of amplitude dividers, 31 stages each.
// Reset is synchronous and clears all valid bits; the index returns to 1.5.
// A stalled response parks one result in a skid register; req_stall rises only then
// and the whole pipeline holds until the skid register drains.
module fresnel_reflectance_core #(
   parameter int COMPONENT_FRAC_BITS = 14
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  frc_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output frc_pkg::rsp_type rsp_data,
   input  logic            csr_wr_en,
   input  logic [13:0]     csr_wr_data
);

   localparam int SH = 2 * COMPONENT_FRAC_BITS;
   localparam int CW = (SH + 2 > 34) ? SH + 2 : 34;
   localparam logic signed [CW-1:0] LIM = CW'(1) << SH;

   logic en;

   // Index register and its derived forms.
   logic [13:0] refr_ff;
   logic [13:0] n_ff;
   logic [27:0] nsq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         refr_ff <= frc_pkg::IOR_RESET;
      end else if (csr_wr_en) begin
         refr_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= (refr_ff < frc_pkg::IOR_ONE) ? frc_pkg::IOR_ONE : refr_ff;
      nsq_ff <= 28'(n_ff) * 28'(n_ff);
   end

   // Stage 1: component products.
   logic               s1_v_ff;
   logic signed [31:0] s1_px_ff, s1_py_ff, s1_pz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_px_ff <= req_data.incident_x * req_data.normal_x;
         s1_py_ff <= req_data.incident_y * req_data.normal_y;
         s1_pz_ff <= req_data.incident_z * req_data.normal_z;
      end
   end

   // Stage 2: dot product, clamp and conversion of the cosine to Q30.
   logic signed [CW-1:0] dot_sum;
   logic signed [CW-1:0] dot_clamp;
   logic [CW-1:0]        mag;
   logic [30:0]          c_cv;
   logic                 s2_v_ff;
   logic [30:0]          s2_c_ff;
   logic                 s2_lv_ff;

   assign dot_sum   = CW'(s1_px_ff) + CW'(s1_py_ff) + CW'(s1_pz_ff);
   assign dot_clamp = (dot_sum > LIM) ? LIM : ((dot_sum < -LIM) ? -LIM : dot_sum);
   assign mag       = dot_clamp[CW-1] ? CW'(-dot_clamp) : CW'(dot_clamp);

   if (SH > 30) begin : g_round
      assign c_cv = 31'((mag + (CW'(1) << (SH - 31))) >> (SH - 30));
   end else begin : g_shift
      assign c_cv = 31'(mag << (30 - SH));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_c_ff  <= c_cv;
         s2_lv_ff <= (dot_clamp > 0);
      end
   end

   // Stage 3: cosine squared.
   logic        s3_v_ff;
   logic [61:0] s3_sq_ff;
   logic [30:0] s3_c_ff;
   logic        s3_lv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_sq_ff <= 62'(s2_c_ff) * 62'(s2_c_ff);
         s3_c_ff  <= s2_c_ff;
         s3_lv_ff <= s2_lv_ff;
      end
   end

   // Stage 4: incident sine squared.
   logic [30:0] c2;
   logic        s4_v_ff;
   logic [30:0] s4_s2i_ff;
   logic [30:0] s4_c_ff;
   logic        s4_lv_ff;

   assign c2 = 31'((s3_sq_ff + (62'(1) << (frc_pkg::QFRAC - 1))) >> frc_pkg::QFRAC);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (en) begin
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_s2i_ff <= (c2 >= frc_pkg::ONE_Q30) ? 31'd0 : frc_pkg::ONE_Q30 - c2;
         s4_c_ff   <= s3_c_ff;
         s4_lv_ff  <= s3_lv_ff;
      end
   end

   // Stage 5: transmitted sine squared for a ray leaving the material.
   logic        s5_v_ff;
   logic [58:0] s5_prod_ff;
   logic [30:0] s5_s2i_ff;
   logic [30:0] s5_c_ff;
   logic        s5_lv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else if (en) begin
         s5_v_ff <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_prod_ff <= 59'(nsq_ff) * 59'(s4_s2i_ff);
         s5_s2i_ff  <= s4_s2i_ff;
         s5_c_ff    <= s4_c_ff;
         s5_lv_ff   <= s4_lv_ff;
      end
   end

   // Snell divider for a ray entering: floor(s2i * 2^24 / n^2).
   logic        da_v;
   logic [66:0] da_side;
   logic [30:0] da_q;

   frc_div #(.QW(frc_pkg::QW), .DW(28), .SW(67)) u_snell_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s5_v_ff),
      .in_side   ({s5_lv_ff, s5_c_ff, s5_prod_ff[58:24]}),
      .in_rem    (28'(s5_s2i_ff[30:7])),
      .in_bits   ({s5_s2i_ff[6:0], 24'd0}),
      .in_den    (nsq_ff),
      .out_valid (da_v),
      .out_side  (da_side),
      .out_quot  (da_q)
   );

   // Stage 6: total internal reflection test and square-root operand.
   logic        da_lv;
   logic [30:0] da_c;
   logic [34:0] da_st2lv;
   logic [30:0] st2;
   logic        tir;
   logic        s6_v_ff;
   logic [30:0] s6_d_ff;
   logic        s6_tir_ff;
   logic [30:0] s6_c_ff;
   logic        s6_lv_ff;

   assign da_lv    = da_side[66];
   assign da_c     = da_side[65:35];
   assign da_st2lv = da_side[34:0];
   assign st2      = da_lv ? ((da_st2lv >= 35'(frc_pkg::ONE_Q30)) ? frc_pkg::ONE_Q30
                                                                  : da_st2lv[30:0])
                           : da_q;
   assign tir      = st2 >= frc_pkg::ONE_Q30;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_v_ff <= 1'b0;
      end else if (en) begin
         s6_v_ff <= da_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_d_ff   <= tir ? 31'd0 : frc_pkg::ONE_Q30 - st2;
         s6_tir_ff <= tir;
         s6_c_ff   <= da_c;
         s6_lv_ff  <= da_lv;
      end
   end

   // Transmitted cosine: floor(sqrt(d * 2^30)).
   logic        sq_v;
   logic [32:0] sq_side;
   logic [30:0] ct;

   frc_sqrt #(.QW(frc_pkg::QW), .SW(33)) u_cos_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s6_v_ff),
      .in_side   ({s6_tir_ff, s6_lv_ff, s6_c_ff}),
      .in_rad    ({1'b0, s6_d_ff, 30'd0}),
      .out_valid (sq_v),
      .out_side  (sq_side),
      .out_root  (ct)
   );

   // Stage 7: index products.
   logic        s7_v_ff;
   logic [44:0] s7_mc_ff, s7_mt_ff;
   logic [30:0] s7_c_ff, s7_ct_ff;
   logic        s7_lv_ff, s7_tir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_v_ff <= 1'b0;
      end else if (en) begin
         s7_v_ff <= sq_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s7_mc_ff  <= 45'(n_ff) * 45'(sq_side[30:0]);
         s7_mt_ff  <= 45'(n_ff) * 45'(ct);
         s7_c_ff   <= sq_side[30:0];
         s7_ct_ff  <= ct;
         s7_lv_ff  <= sq_side[31];
         s7_tir_ff <= sq_side[32];
      end
   end

   // Stage 8: numerators and denominators of the s and p coefficients.
   // For a ray leaving, the incident side carries n and the far side 1.0.
   logic [44:0] c_sh, ct_sh;
   logic [44:0] a1, b1, a2, b2;
   logic        s8_v_ff;
   logic [44:0] s8_ns_ff, s8_np_ff;
   logic [45:0] s8_ds_ff, s8_dp_ff;
   logic        s8_tir_ff;

   assign c_sh  = 45'(s7_c_ff) << 12;
   assign ct_sh = 45'(s7_ct_ff) << 12;
   assign a1    = s7_lv_ff ? c_sh : s7_mc_ff;
   assign b1    = s7_lv_ff ? s7_mt_ff : ct_sh;
   assign a2    = s7_lv_ff ? s7_mc_ff : c_sh;
   assign b2    = s7_lv_ff ? ct_sh : s7_mt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_v_ff <= 1'b0;
      end else if (en) begin
         s8_v_ff <= s7_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s8_ns_ff  <= (a1 >= b1) ? a1 - b1 : b1 - a1;
         s8_ds_ff  <= 46'(a1) + 46'(b1);
         s8_np_ff  <= (a2 >= b2) ? a2 - b2 : b2 - a2;
         s8_dp_ff  <= 46'(a2) + 46'(b2);
         s8_tir_ff <= s7_tir_ff;
      end
   end

   // Amplitude ratios in Q30: floor(num * 2^30 / den).
   logic        rs_v, rp_v;
   logic        rs_tir, rp_tir;
   logic [30:0] rs, rp;

   frc_div #(.QW(frc_pkg::QW), .DW(46), .SW(1)) u_rs_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s8_v_ff),
      .in_side   (s8_tir_ff),
      .in_rem    (46'(s8_ns_ff[44:1])),
      .in_bits   ({s8_ns_ff[0], 30'd0}),
      .in_den    (s8_ds_ff),
      .out_valid (rs_v),
      .out_side  (rs_tir),
      .out_quot  (rs)
   );

   frc_div #(.QW(frc_pkg::QW), .DW(46), .SW(1)) u_rp_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s8_v_ff),
      .in_side   (s8_tir_ff),
      .in_rem    (46'(s8_np_ff[44:1])),
      .in_bits   ({s8_np_ff[0], 30'd0}),
      .in_den    (s8_dp_ff),
      .out_valid (rp_v),
      .out_side  (rp_tir),
      .out_quot  (rp)
   );

   // Stage 9: squared coefficients.
   logic        s9_v_ff;
   logic [61:0] s9_ss_ff, s9_sp_ff;
   logic        s9_tir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_v_ff <= 1'b0;
      end else if (en) begin
         s9_v_ff <= rs_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s9_ss_ff  <= 62'(rs) * 62'(rs);
         s9_sp_ff  <= 62'(rp) * 62'(rp);
         s9_tir_ff <= rs_tir;
      end
   end

   // Final rounding and saturation.
   logic [62:0]      rsum;
   logic [17:0]      kr;
   frc_pkg::rsp_type result;

   assign rsum = 63'(s9_ss_ff) + 63'(s9_sp_ff) + (63'(1) << 44);
   assign kr   = 18'(rsum >> 45);

   always_comb begin
      if (s9_tir_ff) begin
         result.reflectance    = frc_pkg::OUT_ONE;
         result.total_internal = 1'b1;
      end else begin
         result.reflectance    = (kr > 18'(frc_pkg::OUT_ONE)) ? frc_pkg::OUT_ONE : kr[16:0];
         result.total_internal = 1'b0;
      end
   end

   // Output register with one skid entry.
   logic             rsp_valid_ff;
   logic             skid_full_ff;
   frc_pkg::rsp_type rsp_data_ff;
   frc_pkg::rsp_type skid_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (!rsp_stall) begin
            rsp_data_ff  <= skid_data_ff;
            skid_full_ff <= 1'b0;
         end
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= s9_v_ff;
         rsp_data_ff  <= result;
      end else if (s9_v_ff) begin
         skid_data_ff <= result;
         skid_full_ff <= 1'b1;
      end
   end

   assign en        = !skid_full_ff;
   assign req_stall = skid_full_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The skid entry is only ever filled behind a waiting result.
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> rsp_valid_ff)
      else $error("skid register full without a pending response");

   // Both amplitude dividers must stay in lock step.
   a_dividers_aligned: assert property (@(posedge clock) disable iff (reset)
      (rs_v == rp_v) && (!rs_v || (rs_tir == rp_tir)))
      else $error("amplitude dividers out of step");

   // Total internal reflection always reports full reflectance.
   a_tir_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.total_internal) |-> (rsp_data.reflectance == frc_pkg::OUT_ONE))
      else $error("total internal reflection without full reflectance");

   // A held result stays put while the response side stalls.
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("response changed while stalled");

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;

   class reflectance_board;
      frc_pkg::rsp_type pending[$];
      logic [13:0]      ior;
      int               errors;

      function new();
         ior = frc_pkg::IOR_RESET;
         errors = 0;
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned r, bit_w;
         r = 0;
         bit_w = 64'd1 << 62;
         while (bit_w > v) bit_w = bit_w >> 2;
         while (bit_w != 0) begin
            if (v >= r + bit_w) begin
               v = v - (r + bit_w);
               r = (r >> 1) + bit_w;
            end else begin
               r = r >> 1;
            end
            bit_w = bit_w >> 2;
         end
         return r;
      endfunction

      // Quotient num/den in Q30, truncated; num never exceeds den.
      function longint unsigned quot_q30(longint unsigned num, longint unsigned den);
         longint unsigned q;
         q = 0;
         if (num >= den) begin
            q = 1;
            num = num - den;
         end
         for (int i = 0; i < frc_pkg::QFRAC; i++) begin
            num = num << 1;
            q = q << 1;
            if (num >= den) begin
               num = num - den;
               q = q | 1;
            end
         end
         return q;
      endfunction

      function frc_pkg::rsp_type fresnel(frc_pkg::req_type r);
         longint dot, lim;
         longint unsigned mag, c, c2, s2i, st2, ct, ei, et, n, a, b, rs, rp, sum, kr;
         longint unsigned one;
         frc_pkg::rsp_type res;
         one = 64'd1 << frc_pkg::QFRAC;
         dot = longint'(r.incident_x) * longint'(r.normal_x)
             + longint'(r.incident_y) * longint'(r.normal_y)
             + longint'(r.incident_z) * longint'(r.normal_z);
         lim = 64'sd1 << 28;
         if (dot > lim) dot = lim;
         if (dot < -lim) dot = -lim;
         mag = (dot < 0) ? longint'(-dot) : longint'(dot);
         c = mag << 2;
         n = ior;
         if (n < frc_pkg::IOR_ONE) n = frc_pkg::IOR_ONE;
         // A positive cosine means the ray leaves the material.
         if (dot > 0) begin
            ei = n;
            et = frc_pkg::IOR_ONE;
         end else begin
            ei = frc_pkg::IOR_ONE;
            et = n;
         end
         c2 = (c * c + (64'd1 << (frc_pkg::QFRAC - 1))) >> frc_pkg::QFRAC;
         s2i = (c2 >= one) ? 0 : one - c2;
         st2 = (ei * ei * s2i) / (et * et);
         if (st2 >= one) begin
            res.reflectance = frc_pkg::OUT_ONE;
            res.total_internal = 1'b1;
            return res;
         end
         ct = int_sqrt((one - st2) << frc_pkg::QFRAC);
         a = et * c;
         b = ei * ct;
         rs = quot_q30((a >= b) ? a - b : b - a, a + b);
         a = ei * c;
         b = et * ct;
         rp = quot_q30((a >= b) ? a - b : b - a, a + b);
         sum = rs * rs + rp * rp;
         kr = (sum + (64'd1 << 44)) >> 45;
         if (kr > frc_pkg::OUT_ONE) kr = frc_pkg::OUT_ONE;
         res.reflectance = kr[16:0];
         res.total_internal = 1'b0;
         return res;
      endfunction

      function void note_request(frc_pkg::req_type r);
         pending.push_back(fresnel(r));
      endfunction

      function void check_response(frc_pkg::rsp_type got);
         frc_pkg::rsp_type exp_r;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response, actual %p", $realtime, got);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (got.reflectance !== exp_r.reflectance) begin
            $display("%0t: reflectance expected %0d actual %0d", $realtime,
                     exp_r.reflectance, got.reflectance);
            errors++;
         end
         if (got.total_internal !== exp_r.total_internal) begin
            $display("%0t: total_internal expected %0d actual %0d", $realtime,
                     exp_r.total_internal, got.total_internal);
            errors++;
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   frc_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   frc_pkg::rsp_type rsp_data;
   logic             csr_wr_en = 1'b0;
   logic [13:0]      csr_wr_data = '0;

   reflectance_board board = new();
   int  accepted_count = 0;
   int  stall_mode = 0;
   bit  gaps_on = 1'b1;

   fresnel_reflectance_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // Both channels are observed here; outputs still hold their pre-edge values.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            board.note_request(req_data);
            accepted_count <= accepted_count + 1;
         end
         if (rsp_valid && !rsp_stall) board.check_response(rsp_data);
      end
   end

   // The receiver keeps its own pattern and one long hold-off once traffic is under way.
   initial begin
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && accepted_count >= 300) begin
            hold_done = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 2) == 0);
               default: rsp_stall <= ($urandom_range(0, 15) < 12);
            endcase
         end
      end
   end

   task automatic send_request(frc_pkg::req_type r);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
   endtask

   task automatic idle_sender(int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic send_with_gaps(frc_pkg::req_type r);
      send_request(r);
      if (gaps_on && $urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 6));
   endtask

   // Pause the sender until every result is in, then let the pipeline empty out.
   task automatic drain();
      idle_sender(1);
      while (board.pending.size() != 0) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   task automatic write_index(logic [13:0] v);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      board.ior = v;
   endtask

   function automatic void unit_vec(output logic signed [15:0] x, y, z);
      real rx, ry, rz, len;
      len = 0.0;
      while (len < 100.0) begin
         rx = real'($urandom_range(0, 20000)) - 10000.0;
         ry = real'($urandom_range(0, 20000)) - 10000.0;
         rz = real'($urandom_range(0, 20000)) - 10000.0;
         len = $sqrt(rx * rx + ry * ry + rz * rz);
      end
      x = 16'($rtoi(rx / len * 16384.0));
      y = 16'($rtoi(ry / len * 16384.0));
      z = 16'($rtoi(rz / len * 16384.0));
   endfunction

   function automatic frc_pkg::req_type random_request();
      frc_pkg::req_type r;
      if ($urandom_range(0, 9) < 7) begin
         unit_vec(r.incident_x, r.incident_y, r.incident_z);
         unit_vec(r.normal_x, r.normal_y, r.normal_z);
      end else begin
         r = {$urandom(), $urandom(), $urandom()};
      end
      return r;
   endfunction

   function automatic frc_pkg::req_type make_req(int ix, int iy, int iz,
                                                 int nx, int ny, int nz);
      frc_pkg::req_type r;
      r.incident_x = 16'(ix); r.incident_y = 16'(iy); r.incident_z = 16'(iz);
      r.normal_x = 16'(nx); r.normal_y = 16'(ny); r.normal_z = 16'(nz);
      return r;
   endfunction

   task automatic directed_set();
      send_request(make_req(-32768, -32768, -32768, -32768, -32768, -32768));
      send_request(make_req(32767, 32767, 32767, -32768, -32768, -32768));
      send_request(make_req(32767, -32768, 32767, 32767, 32767, 32767));
      send_request(make_req(0, 0, 0, 0, 0, 0));
      // Normal incidence, entering and leaving.
      send_request(make_req(0, 0, -16384, 0, 0, 16384));
      send_request(make_req(0, 0, 16384, 0, 0, 16384));
      // Grazing: cosine exactly zero.
      send_request(make_req(16384, 0, 0, 0, 0, 16384));
      // Steep angles: two rays leaving beyond the critical angle for dense media, one entering.
      send_request(make_req(15000, 0, 6000, 0, 0, 16384));
      send_request(make_req(11585, 0, -11585, 0, 0, 16384));
      send_request(make_req(11585, 0, 11585, 0, 0, 16384));
      send_request(make_req(1, 0, 0, 1, 0, 0));
      send_request(make_req(-1, 0, 0, 1, 0, 0));
   endtask

   initial begin
      logic [13:0] settings[6];
      settings = '{frc_pkg::IOR_RESET, 14'd4096, 14'd16383, 14'd1000, 14'd8192, 14'd0};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 6; p++) begin
         if (p != 0) write_index((p == 5) ? 14'($urandom_range(0, 16383)) : settings[p]);
         stall_mode = p % 3;
         directed_set();
         for (int i = 0; i < 120; i++) begin
            gaps_on = (i < 40) || (i >= 80);
            send_with_gaps(random_request());
         end
         drain();
      end
      if (board.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
